FILE: rtl/tafp_pkg.sv
// ----------------------------------------------------------------------------
// tafp_pkg: shared constants and types for the tick accumulator frame pacer
// Widths of the timestamp, remainder, budget and result fields, the tick
// length and the result record of the serial tick divider.
// ----------------------------------------------------------------------------
package tafp_pkg;

    // tick length in microseconds, 1 to 4095
    localparam int unsigned TICK_US   = 4000;

    localparam int unsigned NOW_W     = 48;
    localparam int unsigned RES_W     = 12;
    localparam int unsigned TOTAL_W   = NOW_W + 1;
    localparam int unsigned RT_W      = 32;
    localparam int unsigned BUDGET_W  = 15;
    localparam int unsigned PHASE_W   = 4;
    localparam int unsigned PHASE_N   = 14;
    localparam int unsigned DLY_W     = BUDGET_W + RES_W;
    localparam int unsigned PROG_FRAC = 16;
    localparam int unsigned PROG_W    = PROG_FRAC + 1;

    localparam int unsigned TCNT_W    = $clog2(TOTAL_W);
    localparam int unsigned PCNT_W    = $clog2(PROG_FRAC);

    // quotient, quotient modulo the phase length, remainder
    typedef struct packed {
        logic [TOTAL_W-1:0] ticks;
        logic [PHASE_W-1:0] tmod;
        logic [RES_W-1:0]   rem;
    } t_tick_res;

endpackage

FILE: rtl/tafp_if.sv
// ----------------------------------------------------------------------------
// tafp_if: valid/ready channels of the frame pacer
// Input item channel, result channel and budget register write channel.
// ----------------------------------------------------------------------------
interface tafp_in_if;
    logic                            valid;
    logic                            ready;
    logic [tafp_pkg::NOW_W-1:0]      now_us;
    logic                            restart;
    logic                            commit;

    modport source (output valid, now_us, restart, commit, input ready);
    modport sink   (input valid, now_us, restart, commit, output ready);
endinterface

interface tafp_out_if;
    logic                            valid;
    logic                            ready;
    logic [tafp_pkg::RT_W-1:0]       running_time;
    logic [tafp_pkg::PHASE_W-1:0]    phase_count;
    logic [tafp_pkg::RT_W-1:0]       frame_ticks;
    logic                            budget_pending;
    logic                            pacing_off;
    logic [tafp_pkg::DLY_W-1:0]      delay_us;
    logic [tafp_pkg::PROG_W-1:0]     progress;

    modport source (output valid, running_time, phase_count, frame_ticks, budget_pending,
                    pacing_off, delay_us, progress, input ready);
    modport sink   (input valid, running_time, phase_count, frame_ticks, budget_pending,
                    pacing_off, delay_us, progress, output ready);
endinterface

interface tafp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tafp_pkg::BUDGET_W-1:0]   frame_tick_budget;

    modport source (output valid, frame_tick_budget, input ready);
    modport sink   (input valid, frame_tick_budget, output ready);
endinterface

FILE: rtl/tafp_tick_div.sv
// ----------------------------------------------------------------------------
// tafp_tick_div: bit-serial divider by the tick length
// Restoring division of the elapsed time, one quotient bit per cycle, with
// the quotient modulo the phase length tracked alongside.
// ----------------------------------------------------------------------------
module tafp_tick_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tafp_pkg::TOTAL_W-1:0] i_total,
    output logic                         o_done,
    output tafp_pkg::t_tick_res          o_res
);

    logic                            r_busy;
    logic                            r_done;
    logic [tafp_pkg::TCNT_W-1:0]     r_cnt;
    logic [tafp_pkg::TOTAL_W-1:0]    r_shift;
    logic [tafp_pkg::RES_W-1:0]      r_rem;
    logic [tafp_pkg::PHASE_W-1:0]    r_mod;

    logic [tafp_pkg::RES_W:0]        rem_sh;
    logic                            q_bit;
    logic [tafp_pkg::RES_W-1:0]      n_rem;
    logic [tafp_pkg::PHASE_W:0]      mod_sh;
    logic [tafp_pkg::PHASE_W-1:0]    n_mod;

    always_comb begin
        rem_sh = {r_rem, r_shift[tafp_pkg::TOTAL_W-1]};
        q_bit  = rem_sh >= (tafp_pkg::RES_W+1)'(tafp_pkg::TICK_US);
        if (q_bit) begin
            n_rem = tafp_pkg::RES_W'(rem_sh - (tafp_pkg::RES_W+1)'(tafp_pkg::TICK_US));
        end else begin
            n_rem = tafp_pkg::RES_W'(rem_sh);
        end
        // quotient so far, modulo the phase length
        mod_sh = {r_mod, q_bit};
        if (mod_sh >= (tafp_pkg::PHASE_W+1)'(tafp_pkg::PHASE_N)) begin
            n_mod = tafp_pkg::PHASE_W'(mod_sh - (tafp_pkg::PHASE_W+1)'(tafp_pkg::PHASE_N));
        end else begin
            n_mod = tafp_pkg::PHASE_W'(mod_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tafp_pkg::TCNT_W'(tafp_pkg::TOTAL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_total;
            r_rem   <= '0;
            r_mod   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[tafp_pkg::TOTAL_W-2:0], q_bit};
            r_rem   <= n_rem;
            r_mod   <= n_mod;
        end
    end

    assign o_done      = r_done;
    assign o_res.ticks = r_shift;
    assign o_res.tmod  = r_mod;
    assign o_res.rem   = r_rem;

endmodule

FILE: rtl/tafp_prog_div.sv
// ----------------------------------------------------------------------------
// tafp_prog_div: bit-serial fraction divider for frame progress
// Restoring division of a numerator below the denominator, giving the
// fraction bits one per cycle.
// ----------------------------------------------------------------------------
module tafp_prog_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tafp_pkg::DLY_W-1:0]     i_num,
    input  logic [tafp_pkg::DLY_W-1:0]     i_den,
    output logic                           o_done,
    output logic [tafp_pkg::PROG_FRAC-1:0] o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [tafp_pkg::PCNT_W-1:0]     r_cnt;
    logic [tafp_pkg::DLY_W-1:0]      r_rem;
    logic [tafp_pkg::DLY_W-1:0]      r_den;
    logic [tafp_pkg::PROG_FRAC-1:0]  r_quot;

    logic [tafp_pkg::DLY_W:0]        rem_sh;
    logic                            q_bit;
    logic [tafp_pkg::DLY_W-1:0]      n_rem;

    always_comb begin
        rem_sh = {r_rem, 1'b0};
        q_bit  = rem_sh >= {1'b0, r_den};
        if (q_bit) begin
            n_rem = tafp_pkg::DLY_W'(rem_sh - {1'b0, r_den});
        end else begin
            n_rem = tafp_pkg::DLY_W'(rem_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tafp_pkg::PCNT_W'(tafp_pkg::PROG_FRAC - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[tafp_pkg::PROG_FRAC-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/tick_accumulator_frame_pacer_unit.sv
// ----------------------------------------------------------------------------
// tick_accumulator_frame_pacer_unit: tick accumulator and frame pacer
// Turns host timestamps into whole ticks, keeps running time, tick phase and
// frame tick count, and reports frame pacing against a tick budget.
// ----------------------------------------------------------------------------
// One item at a time. For an advancing timestamp with the budget still
// pending, the elapsed time is divided by the tick length in a bit-serial
// divider (49 steps), then the progress fraction comes from a 16-step serial
// divider. Once the budget is reached, or with pacing off, the progress
// divider is skipped. A restart or a timestamp that goes backwards skips the
// tick divider. A new item is taken as soon as the previous result is in the
// output register, even if it is not yet taken.
// The budget register may be written at any time the unit is idle.
module tick_accumulator_frame_pacer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tafp_cfg_if.sink    i_cfg,
    tafp_in_if.sink     i_item,
    tafp_out_if.source  o_result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_TSTART,
        S_TDIV,
        S_MUL1,
        S_MUL2,
        S_PSTART,
        S_PDIV,
        S_OUT
    } t_state;

    t_state                              r_state;

    logic [tafp_pkg::BUDGET_W-1:0]       r_budget;
    logic [tafp_pkg::NOW_W-1:0]          r_last;
    logic [tafp_pkg::RES_W-1:0]          r_res;
    logic [tafp_pkg::RT_W-1:0]           r_time;
    logic [tafp_pkg::RT_W-1:0]           r_fa;
    logic [tafp_pkg::PHASE_W-1:0]        r_phase;

    logic [tafp_pkg::NOW_W-1:0]          r_now;
    logic                                r_restart;
    logic                                r_commit;
    logic [tafp_pkg::TOTAL_W-1:0]        r_diff;
    logic                                r_pend;
    logic [tafp_pkg::DLY_W-1:0]          r_gap_us;
    logic [tafp_pkg::DLY_W-1:0]          r_done_us;
    logic [tafp_pkg::DLY_W-1:0]          r_delay;
    logic [tafp_pkg::PROG_W-1:0]         r_prog;

    logic                                r_ovalid;
    logic [tafp_pkg::RT_W-1:0]           r_o_time;
    logic [tafp_pkg::PHASE_W-1:0]        r_o_phase;
    logic [tafp_pkg::RT_W-1:0]           r_o_fa;
    logic                                r_o_pend;
    logic                                r_o_off;
    logic [tafp_pkg::DLY_W-1:0]          r_o_delay;
    logic [tafp_pkg::PROG_W-1:0]         r_o_prog;

    logic                                accept;
    logic [tafp_pkg::TOTAL_W-1:0]        diff_full;
    logic                                backwards;
    logic [tafp_pkg::TOTAL_W-1:0]        total;
    logic                                tick_done;
    tafp_pkg::t_tick_res                 tres;
    logic [tafp_pkg::RT_W:0]             fa_sum;
    logic                                fa_sat;
    logic [tafp_pkg::PHASE_W-1:0]        ph0;
    logic [tafp_pkg::PHASE_W-1:0]        n_phase;
    logic                                pacing_on;
    logic                                n_pend;
    logic [tafp_pkg::BUDGET_W-1:0]       gap;
    logic [tafp_pkg::BUDGET_W-1:0]       mul_a;
    logic [tafp_pkg::DLY_W-1:0]          prod;
    logic                                prog_done;
    logic [tafp_pkg::PROG_FRAC-1:0]      prog_quot;
    logic                                out_load;

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_comb begin
        diff_full = {1'b0, r_now} - {1'b0, r_last};
        backwards = diff_full[tafp_pkg::TOTAL_W-1];
        total     = r_diff + tafp_pkg::TOTAL_W'(r_res);

        // saturate on any tick count that does not fit beside the frame count
        fa_sum = {1'b0, r_fa} + {1'b0, tres.ticks[tafp_pkg::RT_W-1:0]};
        fa_sat = (|tres.ticks[tafp_pkg::TOTAL_W-1:tafp_pkg::RT_W]) || fa_sum[tafp_pkg::RT_W];

        // step the phase backwards by the tick count modulo the phase length
        ph0 = r_phase - 1'b1;
        if (ph0 >= tres.tmod) begin
            n_phase = ph0 - tres.tmod + 1'b1;
        end else begin
            n_phase = ph0 + tafp_pkg::PHASE_W'(tafp_pkg::PHASE_N) - tres.tmod + 1'b1;
        end

        pacing_on = (r_budget != '0);
        n_pend    = pacing_on && (r_fa < tafp_pkg::RT_W'(r_budget));
        gap       = r_budget - r_fa[tafp_pkg::BUDGET_W-1:0];

        // one constant multiplier, shared by the remaining and the done time
        mul_a = (r_state == S_MUL1) ? gap : r_fa[tafp_pkg::BUDGET_W-1:0];
        prod  = tafp_pkg::DLY_W'(mul_a) * tafp_pkg::DLY_W'(tafp_pkg::TICK_US);

        out_load = (r_state == S_OUT) && (!r_ovalid || o_result.ready);
    end

    tafp_tick_div u_tick_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_TSTART),
        .i_total (total),
        .o_done  (tick_done),
        .o_res   (tres)
    );

    tafp_prog_div u_prog_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PSTART),
        .i_num   (r_done_us),
        .i_den   (r_done_us + r_delay),
        .o_done  (prog_done),
        .o_quot  (prog_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_budget <= '0;
            r_last   <= '0;
            r_res    <= '0;
            r_time   <= '0;
            r_fa     <= '0;
            r_phase  <= tafp_pkg::PHASE_W'(tafp_pkg::PHASE_N);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_budget <= i_cfg.frame_tick_budget;
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now     <= i_item.now_us;
                        r_restart <= i_item.restart;
                        r_commit  <= i_item.commit;
                        r_state   <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_last <= r_now;
                    if (r_restart) begin
                        r_phase <= tafp_pkg::PHASE_W'(tafp_pkg::PHASE_N);
                        r_res   <= '0;
                        r_fa    <= '0;
                        r_state <= S_MUL1;
                    end else if (backwards) begin
                        // new baseline, no ticks counted
                        r_res   <= '0;
                        r_state <= S_MUL1;
                    end else begin
                        r_diff  <= diff_full;
                        r_state <= S_TSTART;
                    end
                end
                S_TSTART: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (tick_done) begin
                        r_time  <= r_time + tres.ticks[tafp_pkg::RT_W-1:0];
                        r_fa    <= fa_sat ? '1 : fa_sum[tafp_pkg::RT_W-1:0];
                        r_res   <= tres.rem;
                        r_phase <= n_phase;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_pend   <= n_pend;
                    r_gap_us <= prod;
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_pend) begin
                        r_done_us <= prod + tafp_pkg::DLY_W'(r_res);
                        r_delay   <= r_gap_us - tafp_pkg::DLY_W'(r_res);
                        r_state   <= S_PSTART;
                    end else begin
                        r_delay <= '0;
                        r_prog  <= {pacing_on, {tafp_pkg::PROG_FRAC{1'b0}}};
                        r_state <= S_OUT;
                    end
                end
                S_PSTART: begin
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    if (prog_done) begin
                        r_prog  <= {1'b0, prog_quot};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_o_time  <= r_time;
                        r_o_phase <= r_phase;
                        r_o_fa    <= r_fa;
                        r_o_pend  <= r_pend;
                        r_o_off   <= !pacing_on;
                        r_o_delay <= r_delay;
                        r_o_prog  <= r_prog;
                        if (r_commit) begin
                            r_fa <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.running_time   = r_o_time;
    assign o_result.phase_count    = r_o_phase;
    assign o_result.frame_ticks    = r_o_fa;
    assign o_result.budget_pending = r_o_pend;
    assign o_result.pacing_off     = r_o_off;
    assign o_result.delay_us       = r_o_delay;
    assign o_result.progress       = r_o_prog;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != '0) && (r_phase <= tafp_pkg::PHASE_W'(tafp_pkg::PHASE_N)))
        else $error("tick phase out of range");

    a_tick_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_done |-> (r_state == S_TDIV))
        else $error("tick divider finished outside its wait state");

    a_pending_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.budget_pending) |->
            (!o_result.pacing_off && !o_result.progress[tafp_pkg::PROG_W-1]
             && (o_result.delay_us != '0)))
        else $error("pending result with inconsistent delay or progress");

    a_pacing_off_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.pacing_off) |->
            (!o_result.budget_pending && (o_result.delay_us == '0)
             && (o_result.progress == '0)))
        else $error("pacing off but pacing results not cleared");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_item.ready)
        else $error("input taken while an item is in progress");

endmodule
